[design/quwei_code_entry_to_gb2312_assert.svh]
// assertion macros used by the checker file
`ifndef QUWEI_CODE_ENTRY_TO_GB2312_ASSERT_SVH
`define QUWEI_CODE_ENTRY_TO_GB2312_ASSERT_SVH

// same-cycle implication, held off during reset
`define QWGB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define QWGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/qwgb_pkg.sv]
package qwgb_pkg;

  // keypad function codes
  typedef enum logic [2:0] {
    FUNC_DIGIT = 3'd0,
    FUNC_BACK  = 3'd1,
    FUNC_SPACE = 3'd2,
    FUNC_NEXT  = 3'd3,
    FUNC_PREV  = 3'd4
  } func_t;

  // status codes returned with every word
  typedef enum logic [2:0] {
    ST_NOT_HANDLED = 3'd0,
    ST_IGNORED     = 3'd1,
    ST_EMPTY_BS    = 3'd2,
    ST_CLEARED     = 3'd3,
    ST_SHOW        = 3'd4,
    ST_CHAR        = 3'd5
  } status_t;

  localparam logic [3:0] MAX_DIGIT   = 4'd9;
  localparam logic [3:0] MAX_PAGE    = 4'd9;
  localparam logic [2:0] MAX_DIGITS  = 3'd4;
  localparam logic [6:0] HIGH_ZONE   = 7'd95;
  localparam logic [7:0] HIGH_BASE   = 8'hA8;
  localparam logic [7:0] HIGH_OFFSET = 8'h40;
  localparam logic [7:0] SKIP_CODE   = 8'h7F;
  localparam logic [7:0] LOW_BASE    = 8'hA0;

  // entry state
  typedef struct packed {
    logic [3:0][3:0] digits;
    logic [2:0]      count;
    logic [3:0]      page;
    logic            active;
  } entry_t;

  // one result word
  typedef struct packed {
    status_t    status;
    logic       char_valid;
    logic [7:0] char_high;
    logic [7:0] char_low;
    logic [2:0] digit_count;
    logic [3:0] page_now;
    logic [6:0] zone_now;
  } result_t;

endpackage

[design/qwgb_step.sv]
module qwgb_step (
  input  logic [2:0]        func,
  input  logic [3:0]        digit,
  input  qwgb_pkg::entry_t  cur,
  output qwgb_pkg::entry_t  nxt,
  output qwgb_pkg::result_t res
);

  logic               do_char;
  logic [3:0]         pick;
  logic [6:0]         zone;
  logic [6:0]         pos;
  logic [7:0]         low_hi;
  logic [7:0]         high_b;
  logic [7:0]         low_b;
  qwgb_pkg::status_t  st;

  // next state and status for one keypad word
  always_comb begin
    nxt        = cur;
    do_char    = 1'b0;
    pick       = 4'd1;
    st         = qwgb_pkg::ST_NOT_HANDLED;
    unique case (func)
      qwgb_pkg::FUNC_DIGIT: begin
        if (digit <= qwgb_pkg::MAX_DIGIT && cur.count < qwgb_pkg::MAX_DIGITS) begin
          nxt.digits[cur.count[1:0]] = digit;
          nxt.count = cur.count + 3'd1;
          if (cur.count == 3'd3) begin
            do_char    = 1'b1;
            pick       = (digit == 4'd0) ? 4'd10 : digit;
            st         = qwgb_pkg::ST_CHAR;
          end else begin
            if (cur.count == 3'd2) begin
              nxt.active = 1'b1;
              nxt.page   = digit;
            end
            st = qwgb_pkg::ST_SHOW;
          end
        end
      end
      qwgb_pkg::FUNC_BACK: begin
        if (cur.count == 3'd0) begin
          st = qwgb_pkg::ST_EMPTY_BS;
        end else begin
          nxt.count = cur.count - 3'd1;
          if (cur.count == 3'd1) begin
            st = qwgb_pkg::ST_CLEARED;
          end else begin
            nxt.active = 1'b0;
            st         = qwgb_pkg::ST_SHOW;
          end
        end
      end
      qwgb_pkg::FUNC_SPACE: begin
        if (cur.count == 3'd0) begin
          st = qwgb_pkg::ST_NOT_HANDLED;
        end else if (cur.count != 3'd3) begin
          st = qwgb_pkg::ST_IGNORED;
        end else begin
          do_char    = 1'b1;
          pick       = 4'd1;
          st         = qwgb_pkg::ST_CHAR;
        end
      end
      qwgb_pkg::FUNC_NEXT, qwgb_pkg::FUNC_PREV: begin
        if (cur.active) begin
          if (func == qwgb_pkg::FUNC_NEXT) begin
            if (cur.page < qwgb_pkg::MAX_PAGE) nxt.page = cur.page + 4'd1;
          end else begin
            if (cur.page > 4'd0) nxt.page = cur.page - 4'd1;
          end
          nxt.digits[2] = nxt.page;
          st            = qwgb_pkg::ST_SHOW;
        end
      end
      default: begin
        st = qwgb_pkg::ST_NOT_HANDLED;
      end
    endcase

    // a pick with paging off reloads the page from the third digit
    if (do_char && !cur.active) begin
      nxt.page   = cur.digits[2];
      nxt.active = 1'b1;
    end
  end

  // zone and position
  assign zone = 7'({3'b000, nxt.digits[0]} * 7'd10) + {3'b000, nxt.digits[1]};
  assign pos  = 7'({3'b000, nxt.page} * 7'd10) + {3'b000, pick};

  // character bytes, upper zones skip the 0x7f code
  assign low_hi = {1'b0, pos} + qwgb_pkg::HIGH_OFFSET;
  always_comb begin
    if (zone >= qwgb_pkg::HIGH_ZONE) begin
      high_b = {1'b0, zone} - {1'b0, qwgb_pkg::HIGH_ZONE} + qwgb_pkg::HIGH_BASE;
      low_b  = (low_hi >= qwgb_pkg::SKIP_CODE) ? low_hi + 8'd1 : low_hi;
    end else begin
      high_b = {1'b0, zone} + qwgb_pkg::LOW_BASE;
      low_b  = {1'b0, pos} + qwgb_pkg::LOW_BASE;
    end
  end

  // result word
  always_comb begin
    res.status      = st;
    res.char_valid  = do_char;
    res.char_high   = do_char ? high_b : 8'd0;
    res.char_low    = do_char ? low_b : 8'd0;
    res.digit_count = nxt.count;
    res.page_now    = nxt.page;
    res.zone_now    = (nxt.count >= 3'd2) ? zone : 7'd0;
  end

endmodule

[design/quwei_code_entry_to_gb2312.sv]
// channel | handshake          | payload
// --------+--------------------+------------------------------------------------
// in      | in_valid, in_stall | func, digit
// out     | out_valid, out_stall | status, char_valid, char_high, char_low,
//         |                    | digit_count, page_now, zone_now
//
// one word in per cycle while in_stall is low; a taken word waits in the input register,
// then moves into the result register as the entry state updates, and is offered from there.
// rst clears both stage valids, the digit count, page and paging flag;
// the stored code digits are not reset.
// out_stall holds the result register; in_stall rises only when both stages are full
// and the result is stalled.
module quwei_code_entry_to_gb2312 (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] func,
  input  logic [3:0] digit,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic       char_valid,
  output logic [7:0] char_high,
  output logic [7:0] char_low,
  output logic [2:0] digit_count,
  output logic [3:0] page_now,
  output logic [6:0] zone_now
);

  logic              in_reg_valid;
  logic [2:0]        in_reg_func;
  logic [3:0]        in_reg_digit;
  logic              res_ready;
  logic              in_ready;
  logic              step_go;
  logic [3:0][3:0]   digits;
  logic [2:0]        count;
  logic [3:0]        page;
  logic              active;
  qwgb_pkg::entry_t  cur;
  qwgb_pkg::entry_t  nxt;
  qwgb_pkg::result_t res_next;
  qwgb_pkg::result_t res;

  // stage handshake
  assign res_ready = !out_valid || !out_stall;
  assign in_ready  = !in_reg_valid || res_ready;
  assign in_stall  = !in_ready;
  assign step_go   = in_reg_valid && res_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_reg_func  <= func;
      in_reg_digit <= digit;
    end
  end

  // entry state
  assign cur.digits = digits;
  assign cur.count  = count;
  assign cur.page   = page;
  assign cur.active = active;

  qwgb_step u_step (
    .func  (in_reg_func),
    .digit (in_reg_digit),
    .cur   (cur),
    .nxt   (nxt),
    .res   (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 3'd0;
      page   <= 4'd0;
      active <= 1'b0;
    end else if (step_go) begin
      count  <= nxt.count;
      page   <= nxt.page;
      active <= nxt.active;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      digits <= nxt.digits;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      res <= res_next;
    end
  end

  assign status      = res.status;
  assign char_valid  = res.char_valid;
  assign char_high   = res.char_high;
  assign char_low    = res.char_low;
  assign digit_count = res.digit_count;
  assign page_now    = res.page_now;
  assign zone_now    = res.zone_now;

endmodule

[design/qwgb_checker.sv]
`include "quwei_code_entry_to_gb2312_assert.svh"

module qwgb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] status,
  input logic       char_valid,
  input logic [7:0] char_high,
  input logic [7:0] char_low,
  input logic [2:0] digit_count,
  input logic [3:0] page_now,
  input logic [6:0] zone_now
);

  logic char_ok;
  logic snap_ok;

  // a character comes exactly with the character status, and no bytes without one
  assign char_ok = (char_valid == (status == qwgb_pkg::ST_CHAR)) &&
                   (char_valid || (char_high == 8'd0 && char_low == 8'd0));

  // entry snapshot stays in range, zone only once two digits are in
  assign snap_ok = digit_count <= 3'd4 && page_now <= 4'd9 &&
                   (digit_count >= 3'd2 || zone_now == 7'd0);

  // a stalled input word stays offered
  `QWGB_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid, "input word withdrawn")

  // the input only stalls behind a stalled result
  `QWGB_ASSERT_NOW(a_in_stall, in_stall, out_valid && out_stall, "input stalled needlessly")

  // a stalled result word stays offered
  `QWGB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped")

  `QWGB_ASSERT_NOW(a_char, out_valid, char_ok, "character fields disagree with status")

  `QWGB_ASSERT_NOW(a_snapshot, out_valid, snap_ok, "entry snapshot out of range")

endmodule

bind quwei_code_entry_to_gb2312 qwgb_checker u_qwgb_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .char_valid  (char_valid),
  .char_high   (char_high),
  .char_low    (char_low),
  .digit_count (digit_count),
  .page_now    (page_now),
  .zone_now    (zone_now)
);

[tb/sv/quwei_code_entry_to_gb2312_tb.sv]
`timescale 1ns / 100ps

module quwei_code_entry_to_gb2312_tb;

  // key codes outside the defined functions
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  // position picks for a zero digit and for space
  localparam int unsigned ZERO_PICK = 10;
  localparam int unsigned SPACE_PICK = 1;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT_CYCLES = 200000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] func = qwgb_pkg::FUNC_DIGIT;
  logic [3:0] digit = 4'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] status;
  logic       char_valid;
  logic [7:0] char_high;
  logic [7:0] char_low;
  logic [2:0] digit_count;
  logic [3:0] page_now;
  logic [6:0] zone_now;

  // entry state as the keypad sees it, and the words still owed by the block
  qwgb_pkg::entry_t  ent = '0;
  qwgb_pkg::result_t gb_words_due[$];

  int   mismatches = 0;
  int   cycle_count = 0;
  int   gap_max = 0;
  int   stall_pct = 0;
  int   burst_left = 0;
  bit   wiping = 1'b0;
  logic hold_on = 1'b0;
  event hold_off_ev;

  quwei_code_entry_to_gb2312 dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .digit(digit),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .char_valid(char_valid),
    .char_high(char_high),
    .char_low(char_low),
    .digit_count(digit_count),
    .page_now(page_now),
    .zone_now(zone_now)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // zone from the first two stored digits
  function automatic int unsigned zone_of();
    return ent.digits[0] * 10 + ent.digits[1];
  endfunction

  // both bytes of the character at the given pick on the current page
  function automatic logic [15:0] char_bytes(input int unsigned pick);
    int unsigned zone;
    int unsigned pos;
    int unsigned lo;
    logic [7:0]  hb;
    logic [7:0]  lb;
    zone = zone_of();
    // paging was dropped by a backspace from four digits: reload from the third
    if (!ent.active) begin
      ent.page = ent.digits[2];
      ent.active = 1'b1;
    end
    pos = ent.page * 10 + pick;
    if (zone >= qwgb_pkg::HIGH_ZONE) begin
      hb = 8'(zone - qwgb_pkg::HIGH_ZONE + qwgb_pkg::HIGH_BASE);
      lo = (pos + qwgb_pkg::HIGH_OFFSET) & 8'hFF;
      if (lo >= qwgb_pkg::SKIP_CODE) lo = lo + 1;
      lb = 8'(lo);
    end else begin
      hb = 8'(zone + qwgb_pkg::LOW_BASE);
      lb = 8'(pos + qwgb_pkg::LOW_BASE);
    end
    return {hb, lb};
  endfunction

  // apply one key to the entry state and give the word it should produce
  function automatic qwgb_pkg::result_t press_key(input logic [2:0] f, input logic [3:0] d);
    qwgb_pkg::result_t r;
    r = '0;
    r.status = qwgb_pkg::ST_NOT_HANDLED;
    case (f)
      qwgb_pkg::FUNC_DIGIT: begin
        if (d <= qwgb_pkg::MAX_DIGIT && ent.count < qwgb_pkg::MAX_DIGITS) begin
          ent.digits[ent.count[1:0]] = d;
          ent.count = ent.count + 1'b1;
          if (ent.count == qwgb_pkg::MAX_DIGITS) begin
            {r.char_high, r.char_low} = char_bytes(d == 4'd0 ? ZERO_PICK : d);
            r.char_valid = 1'b1;
            r.status = qwgb_pkg::ST_CHAR;
          end else begin
            if (ent.count == 3'd3) begin
              ent.active = 1'b1;
              ent.page = ent.digits[2];
            end
            r.status = qwgb_pkg::ST_SHOW;
          end
        end
      end
      qwgb_pkg::FUNC_BACK: begin
        if (ent.count == 3'd0) begin
          r.status = qwgb_pkg::ST_EMPTY_BS;
        end else begin
          ent.count = ent.count - 1'b1;
          if (ent.count == 3'd0) begin
            r.status = qwgb_pkg::ST_CLEARED;
          end else begin
            ent.active = 1'b0;
            r.status = qwgb_pkg::ST_SHOW;
          end
        end
      end
      qwgb_pkg::FUNC_SPACE: begin
        if (ent.count == 3'd0) begin
          r.status = qwgb_pkg::ST_NOT_HANDLED;
        end else if (ent.count != 3'd3) begin
          r.status = qwgb_pkg::ST_IGNORED;
        end else begin
          {r.char_high, r.char_low} = char_bytes(SPACE_PICK);
          r.char_valid = 1'b1;
          r.status = qwgb_pkg::ST_CHAR;
        end
      end
      qwgb_pkg::FUNC_NEXT, qwgb_pkg::FUNC_PREV: begin
        if (ent.active) begin
          if (f == qwgb_pkg::FUNC_NEXT) begin
            if (ent.page < qwgb_pkg::MAX_PAGE) ent.page = ent.page + 1'b1;
          end else begin
            if (ent.page > 4'd0) ent.page = ent.page - 1'b1;
          end
          ent.digits[2] = ent.page;
          r.status = qwgb_pkg::ST_SHOW;
        end
      end
      default: ;
    endcase
    r.digit_count = ent.count;
    r.page_now = ent.page;
    r.zone_now = (ent.count >= 3'd2) ? 7'(zone_of()) : 7'd0;
    return r;
  endfunction

  // offer one key and hold it until the block takes it
  task automatic send_key(input logic [2:0] f, input logic [3:0] d);
    in_valid <= 1'b1;
    func <= f;
    digit <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gb_words_due.push_back(press_key(f, d));
  endtask

  // burst pacing on the sending side
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending until every word owed has come back
  task automatic pause_until_empty();
    in_valid <= 1'b0;
    @(posedge clk);
    while (gb_words_due.size() != 0) @(posedge clk);
  endtask

  // mostly well-formed code entry, some noise
  task automatic pick_key(output logic [2:0] f, output logic [3:0] d);
    int roll;
    roll = $urandom_range(0, 99);
    d = 4'($urandom_range(0, qwgb_pkg::MAX_DIGIT));
    f = qwgb_pkg::FUNC_DIGIT;
    if (ent.count == 3'd0) wiping = 1'b0;
    if (roll < 12) begin
      f = 3'($urandom_range(0, 7));
      d = 4'($urandom_range(0, 15));
    end else if (wiping) begin
      f = qwgb_pkg::FUNC_BACK;
    end else if (ent.count < 3'd3) begin
      if (roll < 22) f = qwgb_pkg::FUNC_BACK;
      else if (ent.count == 3'd0 && roll < 45) d = qwgb_pkg::MAX_DIGIT;
    end else if (ent.count == 3'd3) begin
      if (roll < 55) f = roll[0] ? qwgb_pkg::FUNC_NEXT : qwgb_pkg::FUNC_PREV;
      else if (roll < 75) f = qwgb_pkg::FUNC_DIGIT;
      else if (roll < 88) f = qwgb_pkg::FUNC_SPACE;
      else f = qwgb_pkg::FUNC_BACK;
    end else begin
      if (roll < 50) begin
        wiping = 1'b1;
        f = qwgb_pkg::FUNC_BACK;
      end else if (roll < 80) f = qwgb_pkg::FUNC_BACK;
      else if (roll < 86) f = qwgb_pkg::FUNC_SPACE;
      else if (roll < 93) f = qwgb_pkg::FUNC_NEXT;
      else f = qwgb_pkg::FUNC_PREV;
    end
  endtask

  task automatic run_random(input int n);
    logic [2:0] f;
    logic [3:0] d;
    repeat (n) begin
      pick_key(f, d);
      send_key(f, d);
      pace();
    end
  endtask

  // every function, the special cases and the field extremes
  task automatic test_directed();
    send_key(qwgb_pkg::FUNC_BACK, 4'd0);
    send_key(qwgb_pkg::FUNC_SPACE, 4'd0);
    send_key(qwgb_pkg::FUNC_NEXT, 4'd0);
    send_key(FUNC_SPARE_LO, 4'd0);
    send_key(FUNC_SPARE_HI, 4'hF);
    send_key(qwgb_pkg::FUNC_DIGIT, 4'hF);
    send_key(qwgb_pkg::FUNC_DIGIT, 4'd9);
    send_key(qwgb_pkg::FUNC_SPACE, 4'd0);
    send_key(qwgb_pkg::FUNC_DIGIT, 4'd9);
    send_key(qwgb_pkg::FUNC_SPACE, 4'd0);
    send_key(qwgb_pkg::FUNC_DIGIT, 4'd0);
    send_key(qwgb_pkg::FUNC_PREV, 4'd0);
    send_key(qwgb_pkg::FUNC_BACK, 4'd0);
    send_key(qwgb_pkg::FUNC_DIGIT, 4'd9);
    send_key(qwgb_pkg::FUNC_NEXT, 4'd0);
    send_key(qwgb_pkg::FUNC_DIGIT, 4'd3);
    send_key(qwgb_pkg::FUNC_DIGIT, 4'd5);
    send_key(qwgb_pkg::FUNC_SPACE, 4'd0);
    // backspace from four digits, then pick by space and by digit
    send_key(qwgb_pkg::FUNC_BACK, 4'd0);
    send_key(qwgb_pkg::FUNC_SPACE, 4'd0);
    send_key(qwgb_pkg::FUNC_DIGIT, 4'd0);
    send_key(qwgb_pkg::FUNC_BACK, 4'd0);
    send_key(qwgb_pkg::FUNC_DIGIT, 4'd0);
    repeat (4) send_key(qwgb_pkg::FUNC_BACK, 4'd0);
    // top of the lower zones, last page, pick of ten
    send_key(qwgb_pkg::FUNC_DIGIT, 4'd9);
    send_key(qwgb_pkg::FUNC_DIGIT, 4'd4);
    send_key(qwgb_pkg::FUNC_DIGIT, 4'd9);
    send_key(qwgb_pkg::FUNC_DIGIT, 4'd0);
  endtask

  task automatic test_random_keys();
    gap_max = 6;
    stall_pct = 30;
    run_random(600);
  endtask

  // long receiver hold-off while keys keep coming, so the input stalls
  task automatic test_full_backpressure();
    gap_max = 0;
    stall_pct = 0;
    -> hold_off_ev;
    run_random(60);
  endtask

  task automatic test_drain_pause();
    gap_max = 4;
    stall_pct = 20;
    run_random(50);
    pause_until_empty();
    run_random(50);
  endtask

  task automatic test_back_to_back();
    gap_max = 0;
    stall_pct = 0;
    run_random(400);
  endtask

  task automatic test_heavy_stall();
    gap_max = 3;
    stall_pct = 70;
    run_random(360);
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);
    end
  end

  // receiver hold-off, counted here
  initial begin
    forever begin
      @(hold_off_ev);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // compare each word taken from the block with the oldest one owed
  always @(posedge clk) begin
    qwgb_pkg::result_t w;
    if (!rst && out_valid && !out_stall) begin
      if (gb_words_due.size() == 0) begin
        $error("word out with none owed: status %0d", status);
        mismatches++;
      end else begin
        w = gb_words_due.pop_front();
        check_field("status", 8'(w.status), 8'(status));
        check_field("char_valid", 8'(w.char_valid), 8'(char_valid));
        check_field("char_high", w.char_high, char_high);
        check_field("char_low", w.char_low, char_low);
        check_field("digit_count", 8'(w.digit_count), 8'(digit_count));
        check_field("page_now", 8'(w.page_now), 8'(page_now));
        check_field("zone_now", 8'(w.zone_now), 8'(zone_now));
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_keys();
    test_full_backpressure();
    test_drain_pause();
    test_back_to_back();
    test_heavy_stall();
    pause_until_empty();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && gb_words_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/qwgb_pkg.sv
design/qwgb_step.sv
design/quwei_code_entry_to_gb2312.sv
design/qwgb_checker.sv
tb/sv/quwei_code_entry_to_gb2312_tb.sv
